FILE: sv/rational_arith_unit_defines.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Concurrent check wrappers; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

`ifndef SYNTH
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rau check failed");
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rau check failed");
`else
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Request and response word types, operation, order and status codes.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;

   localparam logic [1:0] ORD_LESS    = 2'd0;
   localparam logic [1:0] ORD_EQUAL   = 2'd1;
   localparam logic [1:0] ORD_GREATER = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] a_num;
      logic [30:0]        a_den;
      logic signed [31:0] b_num;
      logic [30:0]        b_den;
   } rau_req_word_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic [1:0]         order;
      logic [1:0]         status;
   } rau_rsp_word_type;

endpackage

FILE: sv/rau_mul.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// Signed word multiplier with a registered double-width product.
// ----------------------------------------------------------------------------
module rau_mul #(
   parameter int WB = 32
) (
   input  logic                   clock,
   input  logic signed [WB-1:0]   mul_a,
   input  logic signed [WB-1:0]   mul_b,
   output logic signed [2*WB-1:0] prod_ff
);

   logic signed [2*WB-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: sv/rau_addsub.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit adder
// Shared add, subtract and compare unit with carry out.
// ----------------------------------------------------------------------------
module rau_addsub #(
   parameter int DW = 64
) (
   input  logic [DW-1:0] alu_a,
   input  logic [DW-1:0] alu_b,
   input  logic          alu_sub,
   output logic [DW-1:0] alu_res,
   output logic          alu_carry
);

   assign {alu_carry, alu_res} = {1'b0, alu_a} + {1'b0, alu_b ^ {DW{alu_sub}}}
                                 + (DW+1)'(alu_sub);

endmodule

FILE: sv/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide or compare two signed fractions and reduce
// the result by its greatest common divisor.
//
//   channel | ports                        | direction
//   req     | req_valid req_stall req_data | in
//   rsp     | rsp_valid rsp_stall rsp_data | out
//
// One word at a time; req_stall is high from accept until the result is loaded.
// Error and unused codes go straight to the output; compare ends after the cross
// products are summed; a zero numerator is not reduced; else common factors of two
// are stripped, a binary GCD loop runs on the shared adder, and numerator and
// denominator are each divided by the GCD with bit-serial division unless it is one.
// Reset clears the sequencer and output valid; a stalled output blocks only the next result.
// ----------------------------------------------------------------------------
`include "rational_arith_unit_defines.svh"

module rational_arith_unit
   import rau_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rau_req_word_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rau_rsp_word_type rsp_data
);

   localparam int WB = WORD_BITS;
   localparam int DW = 2 * WB;
   localparam int KW = $clog2(DW);
   localparam int CW = $clog2(DW);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_NEGN, S_NEGD,
      S_TWOS, S_GCD, S_GSHL, S_DIV, S_CHECK, S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [2:0]          op_ff, op_in;
   logic signed [WB-1:0] an_ff, an_in, bn_ff, bn_in;
   logic [WB-2:0]       ad_ff, ad_in, bd_ff, bd_in;
   logic [DW-1:0]       acc_ff, acc_in, aux_ff, aux_in, den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [DW-1:0]       mag_ff, mag_in, udn_ff, udn_in;
   logic [DW-1:0]       x_ff, x_in, y_ff, y_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [DW-1:0]       r_ff, r_in, q_ff, q_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                dph_ff, dph_in;
   rau_rsp_word_type    res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rau_rsp_word_type    rsp_data_ff, rsp_data_in;

   logic signed [WB-1:0] mul_a, mul_b;
   logic signed [DW-1:0] prod;
   logic [DW-1:0]       alu_a, alu_b, alu_res;
   logic                alu_sub, alu_carry;
   logic [DW-1:0]       trial;
   logic                ovf;
   logic [WB-1:0]       num_w;
   rau_rsp_word_type    res_zero;

   rau_mul #(.WB(WB)) u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   rau_addsub #(.DW(DW)) u_addsub (
      .alu_a     (alu_a),
      .alu_b     (alu_b),
      .alu_sub   (alu_sub),
      .alu_res   (alu_res),
      .alu_carry (alu_carry)
   );

   assign trial    = {r_ff[DW-2:0], q_ff[DW-1]};
   assign res_zero = '{res_num: 32'sd0, res_den: 31'd1, order: ORD_LESS, status: ST_OK};
   assign ovf      = (udn_ff[DW-1:WB-1] != '0) ||
                     (neg_ff ? (mag_ff > (DW'(1) << (WB-1))) : (mag_ff[DW-1:WB-1] != '0));
   assign num_w    = neg_ff ? alu_res[WB-1:0] : mag_ff[WB-1:0];

   // multiplier operand select
   always_comb begin
      mul_a = an_ff;
      mul_b = signed'({1'b0, bd_ff});
      unique case (state_ff)
         S_MUL0: begin
            if (op_ff == OP_MUL) mul_b = bn_ff;
         end
         S_MUL1: begin
            mul_a = bn_ff;
            mul_b = signed'({1'b0, ad_ff});
         end
         S_MUL2: begin
            mul_a = signed'({1'b0, ad_ff});
            mul_b = (op_ff == OP_DIV) ? bn_ff : signed'({1'b0, bd_ff});
         end
         default: begin
         end
      endcase
   end

   // shared adder operand select
   always_comb begin
      alu_a   = x_ff;
      alu_b   = y_ff;
      alu_sub = 1'b1;
      unique case (state_ff)
         S_SUM: begin
            alu_a   = acc_ff;
            alu_b   = aux_ff;
            alu_sub = (op_ff != OP_ADD);
         end
         S_NEGN: begin
            alu_a = '0;
            alu_b = acc_ff;
         end
         S_NEGD: begin
            alu_a = '0;
            alu_b = den_ff;
         end
         S_DIV: begin
            alu_a = trial;
            alu_b = y_ff;
         end
         S_CHECK: begin
            alu_a = '0;
            alu_b = mag_ff;
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      an_in        = an_ff;
      bn_in        = bn_ff;
      ad_in        = ad_ff;
      bd_in        = bd_ff;
      acc_in       = acc_ff;
      aux_in       = aux_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      udn_in       = udn_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      dph_in       = dph_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_data.req_type;
               an_in = req_data.a_num[WB-1:0];
               bn_in = req_data.b_num[WB-1:0];
               ad_in = req_data.a_den[WB-2:0];
               bd_in = req_data.b_den[WB-2:0];
               if (req_data.req_type > OP_CMP) begin
                  res_in   = res_zero;
                  state_in = S_OUT;
               end else if (req_data.a_den[WB-2:0] == '0 ||
                            req_data.b_den[WB-2:0] == '0 ||
                            (req_data.req_type == OP_DIV &&
                             req_data.b_num[WB-1:0] == '0)) begin
                  res_in        = res_zero;
                  res_in.status = ST_ZERO_DEN;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_MUL0;
               end
            end
         end
         S_MUL0: state_in = S_MUL1;
         S_MUL1: begin
            acc_in   = prod;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            aux_in   = prod;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            den_in   = prod;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (op_ff == OP_CMP) begin
               res_in = res_zero;
               if (alu_res == '0) res_in.order = ORD_EQUAL;
               else if (alu_res[DW-1]) res_in.order = ORD_LESS;
               else res_in.order = ORD_GREATER;
               state_in = S_OUT;
            end else begin
               if (op_ff == OP_ADD || op_ff == OP_SUB) acc_in = alu_res;
               state_in = S_NEGN;
            end
         end
         S_NEGN: begin
            neg_in = acc_ff[DW-1] ^ den_ff[DW-1];
            mag_in = acc_ff[DW-1] ? alu_res : acc_ff;
            x_in   = acc_ff[DW-1] ? alu_res : acc_ff;
            if (acc_ff == '0) begin
               res_in   = res_zero;
               state_in = S_OUT;
            end else begin
               state_in = S_NEGD;
            end
         end
         S_NEGD: begin
            udn_in   = den_ff[DW-1] ? alu_res : den_ff;
            y_in     = den_ff[DW-1] ? alu_res : den_ff;
            k_in     = '0;
            state_in = S_TWOS;
         end
         S_TWOS: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = {1'b0, x_ff[DW-1:1]};
               y_in = {1'b0, y_ff[DW-1:1]};
               k_in = k_ff + 1'b1;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            priority if (x_ff == '0) begin
               state_in = S_GSHL;
            end else if (!x_ff[0]) begin
               x_in = {1'b0, x_ff[DW-1:1]};
            end else if (!y_ff[0]) begin
               y_in = {1'b0, y_ff[DW-1:1]};
            end else if (alu_carry) begin
               x_in = {1'b0, alu_res[DW-1:1]};
            end else begin
               x_in = y_ff;
               y_in = x_ff;
            end
         end
         S_GSHL: begin
            if (k_ff != '0) begin
               y_in = {y_ff[DW-2:0], 1'b0};
               k_in = k_ff - 1'b1;
            end else if (y_ff == DW'(1)) begin
               state_in = S_CHECK;
            end else begin
               r_in     = '0;
               q_in     = mag_ff;
               cnt_in   = '0;
               dph_in   = 1'b0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            r_in   = alu_carry ? alu_res : trial;
            q_in   = {q_ff[DW-2:0], alu_carry};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DW-1)) begin
               if (!dph_ff) begin
                  mag_in = {q_ff[DW-2:0], alu_carry};
                  q_in   = udn_ff;
                  r_in   = '0;
                  cnt_in = '0;
                  dph_in = 1'b1;
               end else begin
                  udn_in   = {q_ff[DW-2:0], alu_carry};
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (ovf) begin
               res_in        = res_zero;
               res_in.status = ST_OVERFLOW;
            end else begin
               res_in.res_num = 32'(signed'(num_w));
               res_in.res_den = 31'(udn_ff[WB-2:0]);
               res_in.order   = ORD_LESS;
               res_in.status  = ST_OK;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         an_ff        <= an_in;
         bn_ff        <= bn_in;
         ad_ff        <= ad_in;
         bd_ff        <= bd_in;
         acc_ff       <= acc_in;
         aux_ff       <= aux_in;
         den_ff       <= den_in;
         neg_ff       <= neg_in;
         mag_ff       <= mag_in;
         udn_ff       <= udn_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         k_ff         <= k_in;
         r_ff         <= r_in;
         q_ff         <= q_in;
         cnt_ff       <= cnt_in;
         dph_ff       <= dph_in;
         res_ff       <= res_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RAU_ASSERT_IMPL(a_err_frac, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.res_num == 32'sd0 && rsp_data.res_den == 31'd1)
   `RAU_ASSERT_IMPL(a_den_pos, clock, reset, rsp_valid, rsp_data.res_den != 31'd0)
   `RAU_ASSERT_IMPL(a_order_cmp, clock, reset, rsp_valid && rsp_data.order != ORD_LESS, rsp_data.res_num == 32'sd0 && rsp_data.status == ST_OK)
   `RAU_ASSERT_IMPL(a_gcd_live, clock, reset, state_ff == S_TWOS || state_ff == S_GCD, y_ff != '0)
   `RAU_ASSERT_NEXT(a_accept_busy, clock, reset, state_ff == S_IDLE && req_valid, state_ff != S_IDLE)

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction requests (directed corner cases, then random traffic with
// random idle gaps on both channels and one long output hold-off) and checks
// every result word in order against a fraction predictor with GCD reduction.
// ----------------------------------------------------------------------------
module tb_top;
   import rau_pkg::*;

   localparam int    RANDOM_WORDS   = 500;
   localparam int    MAX_GAP        = 18;
   localparam int    HOLD_AT_RESULT = 40;
   localparam int    HOLD_CYCLES    = 600;
   localparam int    DRAIN_CYCLES   = 500;
   localparam int    IDLE_LIMIT     = 5000;
   localparam longint unsigned NUM_LIMIT = 64'h8000_0000;

   class fraction_scoreboard;
      rau_rsp_word_type pending_results[$];
      int               mismatches;

      function automatic rau_rsp_word_type reduce_fraction(rau_req_word_type w);
         rau_rsp_word_type  r;
         longint            an, ad, bn, bd, num, den, lhs, rhs;
         longint unsigned   mag, udn, x, y, t;
         bit                neg;
         r.res_num = '0;
         r.res_den = 31'd1;
         r.order   = ORD_LESS;
         r.status  = ST_OK;
         an = longint'($signed(w.a_num));
         bn = longint'($signed(w.b_num));
         ad = longint'({33'd0, w.a_den});
         bd = longint'({33'd0, w.b_den});
         if (w.req_type > OP_CMP) begin
            return r;
         end
         if (ad == 0 || bd == 0 || (w.req_type == OP_DIV && bn == 0)) begin
            r.status = ST_ZERO_DEN;
            return r;
         end
         case (w.req_type)
            OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
            OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
            OP_MUL: begin num = an * bn;           den = ad * bd; end
            OP_DIV: begin num = an * bd;           den = ad * bn; end
            default: begin
               lhs = an * bd;
               rhs = bn * ad;
               r.order = (lhs < rhs) ? ORD_LESS : (lhs == rhs) ? ORD_EQUAL : ORD_GREATER;
               return r;
            end
         endcase
         neg = (num < 0);
         mag = neg ? longint'(-num) : longint'(num);
         if (den < 0) begin
            neg = !neg;
            udn = longint'(-den);
         end else begin
            udn = longint'(den);
         end
         if (mag == 0) begin
            return r;
         end
         x = mag;
         y = udn;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         mag = mag / x;
         udn = udn / x;
         if (udn > NUM_LIMIT - 1 || (neg ? mag > NUM_LIMIT : mag > NUM_LIMIT - 1)) begin
            r.status = ST_OVERFLOW;
            return r;
         end
         num = neg ? -longint'(mag) : longint'(mag);
         r.res_num = num[31:0];
         r.res_den = udn[30:0];
         return r;
      endfunction

      function void note_request(rau_req_word_type w);
         pending_results.push_back(reduce_fraction(w));
      endfunction

      function void check_result(rau_rsp_word_type got);
         rau_rsp_word_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word %0d/%0d order %0d status %0d",
                        $signed(got.res_num), got.res_den, got.order, got.status);
            return;
         end
         want = pending_results.pop_front();
         if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
             got.order !== want.order || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %0d/%0d order %0d status %0d, got %0d/%0d order %0d status %0d",
                        $signed(want.res_num), want.res_den, want.order, want.status,
                        $signed(got.res_num), got.res_den, got.order, got.status);
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   rau_req_word_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rau_rsp_word_type rsp_data;

   fraction_scoreboard ledger;
   int                 words_sent;
   int                 results_seen;
   int                 idle_cycles;

   rational_arith_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[rational_arith_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int draw_gap(int index);
      if ((index / 64) % 4 == 1)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [31:0] pick_num();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = 32'($signed($urandom_range(0, 200)) - 100);
         4, 5:       v = $urandom;
         6:          v = 32'($signed($urandom_range(0, 131072)) - 65536);
         7:          v = 32'($signed($urandom_range(0, 33554432)) - 16777216);
         default: begin
            case ($urandom_range(0, 4))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'h0;
               3:       v = 32'hFFFF_FFFF;
               default: v = 32'h1;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic logic [30:0] pick_den();
      logic [30:0] v;
      case ($urandom_range(0, 19))
         0:                  v = '0;
         1, 2, 3:            v = 31'($urandom);
         4:                  v = 31'h7FFF_FFFF;
         5, 6:               v = 31'($urandom_range(1, 65536));
         default:            v = 31'($urandom_range(1, 100));
      endcase
      return v;
   endfunction

   task automatic send_word(input rau_req_word_type w, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      ledger.note_request(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_fraction(input logic [2:0] op, input logic [31:0] an,
                                input logic [30:0] ad, input logic [31:0] bn,
                                input logic [30:0] bd);
      rau_req_word_type w;
      w.req_type = op;
      w.a_num    = an;
      w.a_den    = ad;
      w.b_num    = bn;
      w.b_den    = bd;
      send_word(w, draw_gap(words_sent));
   endtask

   initial begin
      rau_req_word_type w;
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      ledger    = new;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_fraction(OP_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
      send_fraction(OP_SUB, 32'sd1, 31'd2, 32'sd1, 31'd3);
      send_fraction(OP_MUL, -32'sd2, 31'd3, 32'sd3, 31'd4);
      send_fraction(OP_DIV, 32'sd1, 31'd2, -32'sd1, 31'd4);
      send_fraction(OP_DIV, -32'sd6, 31'd4, -32'sd3, 31'd2);
      send_fraction(OP_CMP, 32'sd1, 31'd2, 32'sd1, 31'd3);
      send_fraction(OP_CMP, 32'sd1, 31'd3, 32'sd2, 31'd6);
      send_fraction(OP_CMP, -32'sd1, 31'd2, 32'sd1, 31'd2);
      send_fraction(OP_ADD, 32'sd5, 31'd0, 32'sd1, 31'd3);
      send_fraction(OP_CMP, 32'sd5, 31'd7, 32'sd1, 31'd0);
      send_fraction(OP_DIV, 32'sd5, 31'd7, 32'sd0, 31'd9);
      send_fraction(OP_ADD, 32'sd1, 31'd2, -32'sd1, 31'd2);
      send_fraction(OP_MUL, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1);
      send_fraction(OP_ADD, 32'h7FFF_FFFF, 31'd1, 32'sd1, 31'd1);
      send_fraction(OP_SUB, 32'h8000_0000, 31'd1, 32'sd0, 31'd1);
      send_fraction(OP_MUL, 32'h8000_0000, 31'd1, -32'sd1, 31'd1);
      send_fraction(OP_DIV, 32'sd1, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1);
      send_fraction(OP_MUL, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
      send_fraction(OP_ADD, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
      send_fraction(OP_CMP, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'd1);
      send_fraction(OP_CMP, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
      for (int k = OP_CMP + 1; k < 8; k++)
         send_fraction(3'(k), $urandom, 31'($urandom), $urandom, 31'($urandom));

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(0, 9) == 0)
            w.req_type = 3'($urandom_range(OP_CMP + 1, 7));
         else
            w.req_type = 3'($urandom_range(OP_ADD, OP_CMP));
         w.a_num = pick_num();
         w.a_den = pick_den();
         w.b_num = pick_num();
         w.b_den = pick_den();
         send_word(w, draw_gap(words_sent));
      end
      req_valid <= 1'b0;

      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0)
         $display("[rational_arith_unit] OK");
      else
         $display("[rational_arith_unit] ERROR");
      $finish;
   end

   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (results_seen == HOLD_AT_RESULT)
            hold = HOLD_CYCLES;
         else
            hold = draw_gap(results_seen + 32);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         ledger.check_result(rsp_data);
         results_seen++;
         @(negedge clock);
      end
   end

endmodule

FILE: sim.f
+incdir+sv
sv/rau_pkg.sv
sv/rau_mul.sv
sv/rau_addsub.sv
sv/rational_arith_unit.sv
sim/tb_top.sv
